// File: src/assert_macros.svh
// Assertion helpers included by the compaction map RTL.
// Every check is sampled on i_clk and is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/eicm_pkg.sv
package eicm_pkg;

    // Field widths of the request, response and configuration channels.
    localparam int GIDX_W    = 32;
    localparam int OP_W      = 2;
    localparam int OUT_W     = 11;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 1'b1;

    // Value returned for an excluded, outside or unbuilt index (-1 in 11 bits).
    localparam logic [OUT_W-1:0] NEG_ONE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_MARK   = 2'd1,
        OP_BUILD  = 2'd2,
        OP_LOOKUP = 2'd3
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OUTSIDE   = 2'd1,
        STAT_CAPACITY  = 2'd2,
        STAT_NOT_BUILT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_BUILD
    } t_state;

    // Range checks on the request index and on the configured range.
    typedef struct packed {
        logic in_range;
        logic in_cap;
        logic too_long;
    } t_range_chk;

endpackage

// File: src/eicm_req_if.sv
interface eicm_req_if;
    logic                          valid;
    logic                          ready;
    logic [eicm_pkg::OP_W-1:0]     opcode;
    logic [eicm_pkg::GIDX_W-1:0]   global_index;

    modport source (output valid, output opcode, output global_index, input ready);
    modport sink   (input valid, input opcode, input global_index, output ready);
endinterface

// File: src/eicm_rsp_if.sv
interface eicm_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [eicm_pkg::OUT_W-1:0]  mapped_index;
    logic [eicm_pkg::OUT_W-1:0]         system_count;
    logic [eicm_pkg::STAT_W-1:0]        status;

    modport source (output valid, output mapped_index, output system_count, output status,
                    input ready);
    modport sink   (input valid, input mapped_index, input system_count, input status,
                    output ready);
endinterface

// File: src/eicm_ram.sv
module eicm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/eicm_cfg.sv
module eicm_cfg #(
    parameter int MAP_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [eicm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [eicm_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic [eicm_pkg::GIDX_W-1:0]        i_global_index,
    output eicm_pkg::t_range_chk               o_chk,
    output logic [$clog2(MAP_DEPTH)-1:0]       o_off,
    output logic [$clog2(MAP_DEPTH):0]         o_len
);

    import eicm_pkg::*;

    localparam int AW = $clog2(MAP_DEPTH);

    logic [GIDX_W-1:0] r_start;
    logic [GIDX_W-1:0] r_end;
    logic [GIDX_W-1:0] w_off;
    logic [GIDX_W-1:0] w_long;

    // Range registers; the user must write them only while the block is idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RANGE_START: r_start <= i_cfg_wdata;
                REG_RANGE_END:   r_end   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // An empty or inverted range has length zero.
    assign w_long = (r_end > r_start) ? (r_end - r_start) : '0;
    assign w_off  = i_global_index - r_start;

    assign o_chk.in_range = (i_global_index >= r_start) && (i_global_index < r_end);
    assign o_chk.in_cap   = (w_off < GIDX_W'(MAP_DEPTH));
    assign o_chk.too_long = (w_long > GIDX_W'(MAP_DEPTH));
    assign o_off          = w_off[AW-1:0];
    assign o_len          = w_long[AW:0];

endmodule

// File: src/excluded_index_compaction_map.sv
// Excluded-index compaction map.
// Requests arrive on i_req (opcode, global_index) with a valid/ready handshake;
// each request yields exactly one response on o_rsp (mapped_index, system_count,
// status). The range registers are written through i_cfg_we/i_cfg_idx/i_cfg_wdata;
// the user must write them only while no request is in flight, which the block
// does not enforce. Any write invalidates the built table.
// A mark or a capacity-failed build loads its response as it is accepted; a lookup
// first reads the table; a clear sweeps the bitmap, one entry per cycle; a build
// walks the range, reading the bitmap and writing the table. One request is in
// flight at a time, so marks sustain one per cycle while the receiver takes each
// response; a lookup waits for the registered table read before the next request
// is taken. After reset the bitmap is swept to zero while i_req.ready stays low;
// configuration writes are taken during the sweep.
// The response sits in an output register: a new request is taken when that
// register is empty or is being emptied, so a stalled receiver holds back the
// request side but never loses a response.
module excluded_index_compaction_map #(
    parameter int MAP_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    eicm_req_if.sink                       i_req,
    eicm_rsp_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [eicm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [eicm_pkg::CFG_W-1:0]     i_cfg_wdata
);

    import eicm_pkg::*;

    localparam int AW = $clog2(MAP_DEPTH);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] LAST_IDX = CW'(MAP_DEPTH - 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_k, n_k;
    logic [CW-1:0]     r_len, n_len;
    logic              r_wr_pend, n_wr_pend;
    logic [AW-1:0]     r_wk, n_wk;
    logic [OUT_W-1:0]  r_count, n_count;
    logic              r_built, n_built;
    logic              r_clr_reply, n_clr_reply;
    logic              r_lk_hit, n_lk_hit;
    t_status           r_lk_status, n_lk_status;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_mapped;
    logic [OUT_W-1:0]  r_out_count;
    t_status           r_out_status;

    t_range_chk        w_chk;
    logic [AW-1:0]     w_off;
    logic [CW-1:0]     w_len;
    t_opcode           w_op;
    logic              w_ready;
    logic              w_acc;
    logic              w_build_done;
    logic              w_bm_we;
    logic [AW-1:0]     w_bm_waddr;
    logic              w_bm_wdata;
    logic              w_bm_rdata;
    logic              w_tb_we;
    logic [OUT_W-1:0]  w_tb_wdata;
    logic [OUT_W-1:0]  w_tb_rdata;
    logic              w_load;
    logic [OUT_W-1:0]  w_ld_mapped;
    t_status           w_ld_status;

    // Range registers and index checks.
    eicm_cfg #(.MAP_DEPTH(MAP_DEPTH)) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_global_index (i_req.global_index),
        .o_chk          (w_chk),
        .o_off          (w_off),
        .o_len          (w_len)
    );

    // Exclusion bitmap: written by marks and clears, read by the build walk.
    eicm_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_bm_we),
        .i_waddr (w_bm_waddr),
        .i_wdata (w_bm_wdata),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (w_bm_rdata)
    );

    // Compact table: written by the build walk, read by lookups.
    eicm_ram #(.WIDTH(OUT_W), .DEPTH(MAP_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tb_we),
        .i_waddr (r_wk),
        .i_wdata (w_tb_wdata),
        .i_raddr (w_off),
        .o_rdata (w_tb_rdata)
    );

    assign w_op         = t_opcode'(i_req.opcode);
    assign w_acc        = i_req.valid && w_ready;
    assign w_build_done = (r_k == r_len) && !r_wr_pend;
    assign i_req.ready  = w_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_k == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_acc) begin
                    case (w_op)
                        OP_CLEAR:  n_state = ST_CLEAR;
                        OP_BUILD:  n_state = w_chk.too_long ? ST_IDLE : ST_BUILD;
                        OP_LOOKUP: n_state = ST_LOOK;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOOK:  n_state = ST_IDLE;
            ST_BUILD: begin
                if (w_build_done) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath control and memory accesses for each state.
    always_comb begin
        n_k         = r_k;
        n_len       = r_len;
        n_wr_pend   = 1'b0;
        n_wk        = r_wk;
        n_count     = r_count;
        n_built     = r_built;
        n_clr_reply = r_clr_reply;
        n_lk_hit    = r_lk_hit;
        n_lk_status = r_lk_status;
        w_ready     = 1'b0;
        w_bm_we     = 1'b0;
        w_bm_waddr  = r_k[AW-1:0];
        w_bm_wdata  = 1'b0;
        w_tb_we     = 1'b0;
        w_tb_wdata  = w_bm_rdata ? NEG_ONE : r_count;
        w_load      = 1'b0;
        w_ld_mapped = '0;
        w_ld_status = STAT_OK;
        case (r_state)
            ST_CLEAR: begin
                // Sweep one bitmap entry per cycle.
                w_bm_we = 1'b1;
                n_k     = r_k + CW'(1);
                if (r_k == LAST_IDX) begin
                    n_k = '0;
                    if (r_clr_reply) begin
                        w_load      = 1'b1;
                        n_clr_reply = 1'b0;
                    end
                end
            end
            ST_IDLE: begin
                w_ready = !r_out_valid || o_rsp.ready;
                if (w_acc) begin
                    case (w_op)
                        OP_CLEAR: begin
                            n_k         = '0;
                            n_clr_reply = 1'b1;
                        end
                        OP_MARK: begin
                            w_load = 1'b1;
                            if (!w_chk.in_range) begin
                                w_ld_status = STAT_OUTSIDE;
                            end else if (!w_chk.in_cap) begin
                                w_ld_status = STAT_CAPACITY;
                            end else begin
                                w_bm_we    = 1'b1;
                                w_bm_waddr = w_off;
                                w_bm_wdata = 1'b1;
                            end
                        end
                        OP_BUILD: begin
                            n_count = '0;
                            if (w_chk.too_long) begin
                                n_built     = 1'b0;
                                w_load      = 1'b1;
                                w_ld_status = STAT_CAPACITY;
                            end else begin
                                n_k   = '0;
                                n_len = w_len;
                            end
                        end
                        OP_LOOKUP: begin
                            n_lk_hit = r_built && w_chk.in_range && w_chk.in_cap;
                            if (!r_built) begin
                                n_lk_status = STAT_NOT_BUILT;
                            end else if (!w_chk.in_range || !w_chk.in_cap) begin
                                n_lk_status = STAT_OUTSIDE;
                            end else begin
                                n_lk_status = STAT_OK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOOK: begin
                // Table data for the accepted lookup is available now.
                w_load      = 1'b1;
                w_ld_mapped = r_lk_hit ? w_tb_rdata : NEG_ONE;
                w_ld_status = r_lk_status;
            end
            ST_BUILD: begin
                // Write the entry whose bitmap bit was read last cycle.
                if (r_wr_pend) begin
                    w_tb_we = 1'b1;
                    if (!w_bm_rdata) begin
                        n_count = r_count + OUT_W'(1);
                    end
                end
                // Issue the bitmap read for the next index of the range.
                if (r_k != r_len) begin
                    n_wr_pend = 1'b1;
                    n_wk      = r_k[AW-1:0];
                    n_k       = r_k + CW'(1);
                end else if (!r_wr_pend) begin
                    w_load  = 1'b1;
                    n_built = 1'b1;
                end
            end
            default: ;
        endcase
        // A range change invalidates the table.
        if (i_cfg_we) begin
            n_built = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_k         <= '0;
            r_len       <= '0;
            r_wr_pend   <= 1'b0;
            r_count     <= '0;
            r_built     <= 1'b0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_len       <= n_len;
            r_wr_pend   <= n_wr_pend;
            r_count     <= n_count;
            r_built     <= n_built;
            r_clr_reply <= n_clr_reply;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_wk        <= n_wk;
        r_lk_hit    <= n_lk_hit;
        r_lk_status <= n_lk_status;
        if (w_load) begin
            r_out_mapped <= w_ld_mapped;
            r_out_count  <= n_count;
            r_out_status <= w_ld_status;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.mapped_index = $signed(r_out_mapped);
    assign o_rsp.system_count = r_out_count;
    assign o_rsp.status       = r_out_status;

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_load_into_free, w_load, !r_out_valid || o_rsp.ready, "response overwritten")
    `ASSERT_IMPLIES(a_walk_bound, r_state == ST_BUILD, r_k <= r_len, "build walk past range")
    `ASSERT_NEXT(a_look_reply, r_state == ST_LOOK, r_out_valid, "lookup gave no response")
    `ASSERT_NEXT(a_cfg_unbuilds, i_cfg_we, !r_built, "table still built after range write")
    `ASSERT_IMPLIES(a_unbuilt_neg, r_out_valid && r_out_status == STAT_NOT_BUILT,
                    r_out_mapped == NEG_ONE, "unbuilt lookup not -1")

endmodule
